// File: src/rpwdb_pkg.sv
package rpwdb_pkg;

  // Item operation codes.
  localparam logic OP_DRAW  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Rotation codes.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BGR_ORDER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_END   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_END   = 3'd7;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values.
  localparam logic [9:0] PANEL_RST    = 10'd512;
  localparam logic [9:0] CLIP_END_RST = 10'd512;

  // Width of the row-major address sum py * w + px with 10-bit operands.
  localparam int unsigned SUM_W = 21;

  typedef struct packed {
    logic [9:0] panel_width;
    logic [9:0] panel_height;
    logic [1:0] rotation;
    logic       bgr_order;
    logic [9:0] clip_x_min;
    logic [9:0] clip_y_min;
    logic [9:0] clip_x_end;
    logic [9:0] clip_y_end;
  } rpwdb_cfg_t;

  typedef struct packed {
    logic              operation;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } rpwdb_in_t;

  typedef struct packed {
    logic       pixel_written;
    logic       box_valid;
    logic [9:0] box_x_low;
    logic [9:0] box_y_low;
    logic [8:0] box_x_high;
    logic [8:0] box_y_high;
  } rpwdb_out_t;

  // Transformed pixel handed from the front stage to the memory stage.
  typedef struct packed {
    logic        operation;
    logic        ok;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [15:0] word;
  } rpwdb_pix_t;

endpackage

// File: src/rpwdb_chan_if.sv
interface rpwdb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/rpwdb_ram.sv
module rpwdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rpwdb_xform.sv
module rpwdb_xform
  import rpwdb_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  rpwdb_in_t  item_i,
  input  rpwdb_cfg_t cfg_i,
  input  logic [9:0] eff_w_i,
  input  logic [9:0] eff_h_i,
  output rpwdb_pix_t pix_o
);

  logic signed [12:0] xs, ys, ws, hs, px_s, py_s;
  logic               in_clip, in_panel;
  logic [7:0]         r_c, b_c;
  rpwdb_pix_t         pix_d, pix_q;

  always_comb begin
    xs = {item_i.pos_x[11], item_i.pos_x};
    ys = {item_i.pos_y[11], item_i.pos_y};
    ws = $signed({3'b000, eff_w_i});
    hs = $signed({3'b000, eff_h_i});

    in_clip = (xs >= $signed({3'b000, cfg_i.clip_x_min})) &&
              (xs <  $signed({3'b000, cfg_i.clip_x_end})) &&
              (ys >= $signed({3'b000, cfg_i.clip_y_min})) &&
              (ys <  $signed({3'b000, cfg_i.clip_y_end}));

    unique case (cfg_i.rotation)
      ROT_90: begin
        px_s = ws - ys - 13'sd1;
        py_s = xs;
      end
      ROT_180: begin
        px_s = ws - xs - 13'sd1;
        py_s = hs - ys - 13'sd1;
      end
      ROT_270: begin
        px_s = ys;
        py_s = hs - xs - 13'sd1;
      end
      default: begin
        px_s = xs;
        py_s = ys;
      end
    endcase

    in_panel = !px_s[12] && !py_s[12] && (px_s < ws) && (py_s < hs);

    // In BGR mode red and blue trade places before packing to 565.
    r_c = cfg_i.bgr_order ? item_i.blue : item_i.red;
    b_c = cfg_i.bgr_order ? item_i.red  : item_i.blue;

    pix_d.operation = item_i.operation;
    pix_d.ok        = in_clip && in_panel;
    pix_d.px        = px_s[9:0];
    pix_d.py        = py_s[9:0];
    pix_d.word      = {r_c[7:3], item_i.green[7:2], b_c[7:3]};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// File: src/rotated_pixel_writer_dirty_box_unit.sv
// Rotated pixel writer with dirty-box tracking.
//
// Items enter on in_i and each one gives exactly one result item on out_o.
// A draw item clips its logical pixel, rotates it into panel coordinates,
// packs the color to RGB565 and writes it to the frame memory only when the
// stored word differs; the result then has pixel_written set and the dirty box
// grows to cover the pixel. A flush item returns the dirty box (box_valid when
// it is non-empty) and empties it again.
// Configuration registers are written on cfg_we_i / cfg_idx_i / cfg_data_i and
// take effect for the next item; write them only while the block is idle.
// The front stage registers an item as it is accepted; its result is loaded
// into the output register after the address multiply, the frame memory read
// and the compare/write-back, and can then be taken from out_o.
// The single read-modify-write of the frame memory serializes items, so a new
// item is accepted only once the last one has left the compare stage.
// After reset the frame memory is cleared one word per cycle through all of its
// MAX_WIDTH * MAX_HEIGHT words; in_i.ready stays low until that ends.
// The output register holds a finished result while the receiver stalls; the
// next item is still accepted and waits in the compare stage until the
// output register is free.
module rotated_pixel_writer_dirty_box_unit
  import rpwdb_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rpwdb_chan_if.sink            in_i,
  rpwdb_chan_if.source          out_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EXT_W  = (ADDR_W > SUM_W) ? ADDR_W : SUM_W;
  localparam logic [EXT_W:0]    DEPTH_C   = (EXT_W + 1)'(DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [9:0]        RST_EFF_W = 10'((MAX_WIDTH < 512) ? MAX_WIDTH : 512);
  localparam logic [9:0]        RST_EFF_H = 10'((MAX_HEIGHT < 512) ? MAX_HEIGHT : 512);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;

  logic [2:0]        state_q, state_d;
  rpwdb_cfg_t        cfg_q;
  logic [9:0]        eff_w, eff_h;
  logic [ADDR_W-1:0] clr_q;
  logic              in_acc;
  rpwdb_pix_t        pix;
  logic [19:0]       prod_q;
  logic [SUM_W-1:0]  addr_sum;
  logic [EXT_W-1:0]  addr_ext;
  logic [ADDR_W-1:0] addr_q;
  logic              inrange_q;
  logic [15:0]       rdata;
  logic              fire, wr_hit, ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [9:0]        box_xl_q, box_yl_q, box_xh_q, box_yh_q;
  logic              box_ne;
  rpwdb_out_t        out_q, out_d;
  logic              out_valid_q;

  // Configuration registers; the panel size saturates to the memory geometry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.panel_width  <= PANEL_RST;
      cfg_q.panel_height <= PANEL_RST;
      cfg_q.rotation     <= ROT_0;
      cfg_q.bgr_order    <= 1'b0;
      cfg_q.clip_x_min   <= '0;
      cfg_q.clip_y_min   <= '0;
      cfg_q.clip_x_end   <= CLIP_END_RST;
      cfg_q.clip_y_end   <= CLIP_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PANEL_WIDTH:  cfg_q.panel_width  <= cfg_data_i;
        CFG_PANEL_HEIGHT: cfg_q.panel_height <= cfg_data_i;
        CFG_ROTATION:     cfg_q.rotation     <= cfg_data_i[1:0];
        CFG_BGR_ORDER:    cfg_q.bgr_order    <= cfg_data_i[0];
        CFG_CLIP_X_MIN:   cfg_q.clip_x_min   <= cfg_data_i;
        CFG_CLIP_Y_MIN:   cfg_q.clip_y_min   <= cfg_data_i;
        CFG_CLIP_X_END:   cfg_q.clip_x_end   <= cfg_data_i;
        CFG_CLIP_Y_END:   cfg_q.clip_y_end   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (int'(cfg_q.panel_width) > MAX_WIDTH) ? 10'(MAX_WIDTH) : cfg_q.panel_width;
  assign eff_h = (int'(cfg_q.panel_height) > MAX_HEIGHT) ? 10'(MAX_HEIGHT)
                                                         : cfg_q.panel_height;

  // Input is taken only when the pipeline holds no item.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  rpwdb_xform u_xform (
    .clk_i   (clk_i),
    .load_i  (in_acc),
    .item_i  (in_i.data),
    .cfg_i   (cfg_q),
    .eff_w_i (eff_w),
    .eff_h_i (eff_h),
    .pix_o   (pix)
  );

  // Row-major address: the product is registered before the add.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= pix.py * eff_w;
    end
  end

  assign addr_sum = SUM_W'(prod_q) + SUM_W'(pix.px);
  assign addr_ext = EXT_W'(addr_sum);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      addr_q    <= addr_ext[ADDR_W-1:0];
      inrange_q <= ({1'b0, addr_ext} < DEPTH_C);
    end
  end

  // The compare stage retires the item once the output register is free.
  assign fire   = (state_q == ST_CMP) && (!out_valid_q || out_o.ready);
  assign wr_hit = (pix.operation == OP_DRAW) && pix.ok && inrange_q && (rdata != pix.word);
  assign ram_we = (state_q == ST_CLEAR) || (fire && wr_hit);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_waddr = addr_q;
      ram_wdata = pix.word;
    end
  end

  rpwdb_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == ST_READ),
    .raddr_i (addr_ext[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_MUL;
      ST_MUL:   state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      ST_CMP:   if (fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Dirty box: grows on a changed pixel, returns to empty on every flush.
  assign box_ne = (box_xl_q <= box_xh_q) && (box_yl_q <= box_yh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_xl_q <= RST_EFF_W;
      box_yl_q <= RST_EFF_H;
      box_xh_q <= '0;
      box_yh_q <= '0;
    end else if (fire) begin
      if (pix.operation == OP_FLUSH) begin
        box_xl_q <= eff_w;
        box_yl_q <= eff_h;
        box_xh_q <= '0;
        box_yh_q <= '0;
      end else if (wr_hit) begin
        if (pix.px < box_xl_q) box_xl_q <= pix.px;
        if (pix.py < box_yl_q) box_yl_q <= pix.py;
        if (pix.px > box_xh_q) box_xh_q <= pix.px;
        if (pix.py > box_yh_q) box_yh_q <= pix.py;
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (pix.operation == OP_FLUSH) begin
      if (box_ne) begin
        out_d.box_valid  = 1'b1;
        out_d.box_x_low  = box_xl_q;
        out_d.box_y_low  = box_yl_q;
        out_d.box_x_high = box_xh_q[8:0];
        out_d.box_y_high = box_yh_q[8:0];
      end
    end else begin
      out_d.pixel_written = wr_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("frame memory written while idle");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_i.ready)
    else $error("item accepted during clearing pass");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("retired item did not reach the output register");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.pixel_written && out_q.box_valid))
    else $error("result marks both a write and a box");

  a_box_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && wr_hit) |=> (box_xl_q <= box_xh_q) && (box_yl_q <= box_yh_q))
    else $error("dirty box empty after a pixel write");
`endif

endmodule

// File: dv/rotated_pixel_writer_dirty_box_unit_tb.sv
`timescale 1ns / 1ps

module rotated_pixel_writer_dirty_box_unit_tb
  import rpwdb_pkg::*;
();

  localparam int FB_W = 512;
  localparam int FB_H = 512;
  localparam int FB_WORDS = FB_W * FB_H;

  // This limit covers the frame memory clear after reset and the stimulus,
  // even with heavy stalls, and is several times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  localparam int N_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 104;

  // Predicts the result of every accepted item. It keeps its own copy of the
  // registers, the frame memory and the dirty box, and holds the expected
  // results in order until the block returns them.
  class framebuffer_scoreboard;
    bit [15:0]  frame_words [FB_WORDS];
    bit [9:0]   panel_w, panel_h;
    bit [1:0]   rot;
    bit         bgr;
    bit [9:0]   clip_xmin, clip_ymin, clip_xend, clip_yend;
    int         box_xl, box_yl, box_xh, box_yh;
    rpwdb_out_t expected_q [$];
    int unsigned mismatches, n_draw, n_stored, n_flush, n_box;

    function new();
      panel_w   = PANEL_RST;
      panel_h   = PANEL_RST;
      rot       = ROT_0;
      bgr       = 1'b0;
      clip_xmin = '0;
      clip_ymin = '0;
      clip_xend = CLIP_END_RST;
      clip_yend = CLIP_END_RST;
      empty_box();
    endfunction

    function int eff_w();
      return (panel_w > FB_W) ? FB_W : int'(panel_w);
    endfunction

    function int eff_h();
      return (panel_h > FB_H) ? FB_H : int'(panel_h);
    endfunction

    function void empty_box();
      box_xl = eff_w();
      box_yl = eff_h();
      box_xh = 0;
      box_yh = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PANEL_WIDTH:  panel_w = val;
        CFG_PANEL_HEIGHT: panel_h = val;
        CFG_ROTATION:     rot = val[1:0];
        CFG_BGR_ORDER:    bgr = val[0];
        CFG_CLIP_X_MIN:   clip_xmin = val;
        CFG_CLIP_Y_MIN:   clip_ymin = val;
        CFG_CLIP_X_END:   clip_xend = val;
        CFG_CLIP_Y_END:   clip_yend = val;
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_input(rpwdb_in_t it);
      rpwdb_out_t res;
      int         x, y, w, h, px, py, addr;
      logic [7:0] r, b;
      logic [15:0] word;
      res = '0;
      w = eff_w();
      h = eff_h();
      if (it.operation == OP_FLUSH) begin
        n_flush++;
        if (box_xl <= box_xh && box_yl <= box_yh) begin
          res.box_valid  = 1'b1;
          res.box_x_low  = 10'(box_xl);
          res.box_y_low  = 10'(box_yl);
          res.box_x_high = 9'(box_xh);
          res.box_y_high = 9'(box_yh);
          n_box++;
        end
        empty_box();
      end else begin
        n_draw++;
        x = $signed(it.pos_x);
        y = $signed(it.pos_y);
        if (x >= int'(clip_xmin) && x < int'(clip_xend) &&
            y >= int'(clip_ymin) && y < int'(clip_yend)) begin
          case (rot)
            ROT_90: begin
              px = w - 1 - y;
              py = x;
            end
            ROT_180: begin
              px = w - 1 - x;
              py = h - 1 - y;
            end
            ROT_270: begin
              px = y;
              py = h - 1 - x;
            end
            default: begin
              px = x;
              py = y;
            end
          endcase
          if (px >= 0 && px < w && py >= 0 && py < h) begin
            addr = py * w + px;
            r = bgr ? it.blue : it.red;
            b = bgr ? it.red : it.blue;
            word = {r[7:3], it.green[7:2], b[7:3]};
            if (addr < FB_WORDS && frame_words[addr] != word) begin
              frame_words[addr] = word;
              if (px < box_xl) box_xl = px;
              if (py < box_yl) box_yl = py;
              if (px > box_xh) box_xh = px;
              if (py > box_yh) box_yh = py;
              res.pixel_written = 1'b1;
              n_stored++;
            end
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    // Compares one returned result with the oldest expectation.
    function void check_result(rpwdb_out_t got);
      rpwdb_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: written=%0b valid=%0b",
                   got.pixel_written, got.box_valid);
        return;
      end
      want = expected_q.pop_front();
      if (got.pixel_written !== want.pixel_written || got.box_valid !== want.box_valid ||
          got.box_x_low !== want.box_x_low || got.box_y_low !== want.box_y_low ||
          got.box_x_high !== want.box_x_high || got.box_y_high !== want.box_y_high) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: expected written=%0b valid=%0b box=(%0d,%0d)-(%0d,%0d),",
                    " got written=%0b valid=%0b box=(%0d,%0d)-(%0d,%0d)"},
                   want.pixel_written, want.box_valid, want.box_x_low, want.box_y_low,
                   want.box_x_high, want.box_y_high,
                   got.pixel_written, got.box_valid, got.box_x_low, got.box_y_low,
                   got.box_x_high, got.box_y_high);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rpwdb_chan_if #(.T(rpwdb_in_t))  in_ch ();
  rpwdb_chan_if #(.T(rpwdb_out_t)) out_ch ();

  rotated_pixel_writer_dirty_box_unit #(
    .MAX_WIDTH (FB_W),
    .MAX_HEIGHT(FB_H)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  framebuffer_scoreboard sb;

  // Percentages of cycles in which the sender holds back an item and in
  // which the receiver refuses a result. Each register setting runs with
  // one of four mixes, so gaps land on every stage of the pipeline.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  rpwdb_in_t  last_draw;
  bit         have_last;
  rpwdb_cfg_t setting_list [N_SETTINGS];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver decides at each falling edge whether it takes a result at
  // the next rising edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Results are sampled at the rising edge, before the block's own updates
  // of that edge become visible.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Offers one item, starting and ending at a falling edge. The valid line
  // is left high on return so that a following item keeps it asserted.
  task automatic send_item(rpwdb_in_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  // Writes one register; starts and ends at a falling edge and leaves the
  // write enable high for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Loads a full setting. The rotation and color order registers get random
  // upper bits, since the block is meant to keep only the low bits.
  task automatic load_setting(rpwdb_cfg_t c);
    logic [7:0] pad;
    pad = $urandom_range(255);
    write_reg(CFG_PANEL_WIDTH, c.panel_width);
    write_reg(CFG_PANEL_HEIGHT, c.panel_height);
    write_reg(CFG_ROTATION, {pad, c.rotation});
    write_reg(CFG_BGR_ORDER, {pad, ~pad[0], c.bgr_order});
    write_reg(CFG_CLIP_X_MIN, c.clip_x_min);
    write_reg(CFG_CLIP_Y_MIN, c.clip_y_min);
    write_reg(CFG_CLIP_X_END, c.clip_x_end);
    write_reg(CFG_CLIP_Y_END, c.clip_y_end);
    cfg_we_i <= 1'b0;
  endtask

  // Drops valid and waits until every expected result has come back, so
  // the block is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic rpwdb_in_t draw_item(int x, int y, int r, int g, int b);
    rpwdb_in_t it;
    it.operation = OP_DRAW;
    it.pos_x     = 12'(x);
    it.pos_y     = 12'(y);
    it.red       = 8'(r);
    it.green     = 8'(g);
    it.blue      = 8'(b);
    return it;
  endfunction

  function automatic rpwdb_in_t flush_item();
    rpwdb_in_t it;
    it = '0;
    it.operation = OP_FLUSH;
    return it;
  endfunction

  // Mostly coordinates a little around the visible area, so that clipping
  // and bounds edges are hit often; now and then any 12-bit value.
  function automatic logic [11:0] pick_coord(int span);
    if ($urandom_range(99) < 10) return 12'($urandom);
    return 12'(int'($urandom_range(span + 3)) - 2);
  endfunction

  // One random item. Flushes are about one in eight; some draws repeat the
  // last draw exactly to reach the unchanged-color case, and a few use
  // black, which matches a freshly cleared word.
  function automatic rpwdb_in_t make_item(int span);
    rpwdb_in_t it;
    int        sel;
    sel = $urandom_range(99);
    it  = rpwdb_in_t'({$urandom, $urandom});
    if (sel < 12) begin
      it.operation = OP_FLUSH;
    end else if (sel < 24 && have_last) begin
      it = last_draw;
    end else begin
      it.operation = OP_DRAW;
      it.pos_x     = pick_coord(span);
      it.pos_y     = pick_coord(span);
      if (sel < 29) begin
        it.red   = '0;
        it.green = '0;
        it.blue  = '0;
      end
      last_draw = it;
      have_last = 1'b1;
    end
    return it;
  endfunction

  initial begin
    int w, h, span;
    rpwdb_in_t directed_q [$];

    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    have_last      = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;

    // Settings, in field order: width, height, rotation, color order and the
    // clip rectangle. They cover the reset values, every rotation, both
    // color orders, a saturating panel size, a zero and a one-pixel panel,
    // an empty and inverted clip, and a clip wider than the panel.
    setting_list[0] = '{10'd512, 10'd512, ROT_0, 1'b0, 10'd0, 10'd0, 10'd512, 10'd512};
    setting_list[1] = '{10'd16, 10'd12, ROT_90, 1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023};
    setting_list[2] = '{10'd1023, 10'd1023, ROT_180, 1'b0, 10'd3, 10'd5, 10'd500, 10'd510};
    setting_list[3] = '{10'd20, 10'd9, ROT_270, 1'b1, 10'd2, 10'd1, 10'd18, 10'd30};
    setting_list[4] = '{10'd0, 10'd0, ROT_0, 1'b0, 10'd0, 10'd0, 10'd512, 10'd512};
    setting_list[5] = '{10'd1, 10'd1, ROT_90, 1'b0, 10'd0, 10'd0, 10'd1, 10'd1};
    setting_list[6] = '{10'd64, 10'd32, ROT_0, 1'b1, 10'd40, 10'd30, 10'd40, 10'd20};
    setting_list[7] = '{10'd511, 10'd300, ROT_270, 1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items on the reset setting. The first flush finds an empty
    // box, a black draw matches the cleared memory, a repeated color is not
    // stored again, two opposite panel corners are written, coordinates just outside
    // and at both ends of the signed range are clipped, and a color whose
    // dropped low bits are all that differ packs to the stored word.
    directed_q.push_back(flush_item());
    directed_q.push_back(draw_item(0, 0, 0, 0, 0));
    directed_q.push_back(draw_item(0, 0, 255, 255, 255));
    directed_q.push_back(draw_item(0, 0, 255, 255, 255));
    directed_q.push_back(draw_item(511, 511, 255, 0, 0));
    directed_q.push_back(draw_item(512, 0, 1, 2, 3));
    directed_q.push_back(draw_item(0, 512, 1, 2, 3));
    directed_q.push_back(draw_item(-1, 5, 1, 2, 3));
    directed_q.push_back(draw_item(-2048, -2048, 255, 255, 255));
    directed_q.push_back(draw_item(2047, 2047, 255, 255, 255));
    directed_q.push_back(draw_item(100, 200, 8'hAA, 8'h55, 8'h0F));
    directed_q.push_back(flush_item());
    directed_q.push_back(flush_item());
    directed_q.push_back(draw_item(5, 7, 8'h07, 8'h03, 8'h07));
    directed_q.push_back(draw_item(5, 7, 8'h08, 8'h04, 8'h08));
    directed_q.push_back(draw_item(5, 7, 8'h0F, 8'h07, 8'h0F));
    directed_q.push_back(flush_item());
    foreach (directed_q[i]) send_item(directed_q[i]);

    // Random part: one block of items per setting, each with one of four mixes
    // of sender gaps and receiver stalls. Registers change only once every
    // result is back.
    for (int s = 0; s < N_SETTINGS; s++) begin
      drain();
      load_setting(setting_list[s]);
      case (s % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      w    = sb.eff_w();
      h    = sb.eff_h();
      span = (w > h) ? w : h;
      have_last = 1'b0;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) send_item(make_item(span));
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d draws (%0d stored a new word) and %0d flushes (%0d with a box)",
             sb.n_draw, sb.n_stored, sb.n_flush, sb.n_box);
    $display("over %0d register settings, all four rotations and four idle mixes.",
             N_SETTINGS + 1);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
